// ===== design/sdf_pkg.sv =====
package sdf_pkg;

    localparam int NUM_STAGES = 60;
    localparam int STG_SQUARE = 1;
    localparam int STG_SUM = 2;
    localparam int STG_ROOT_FIRST = 3;
    localparam int STG_ROOT_LAST = 36;
    localparam int STG_SELECT = 37;
    localparam int STG_DIV_FIRST = 38;
    localparam int STG_DIV_LAST = 54;
    localparam int STG_MUL1 = 55;
    localparam int STG_MUL2 = 56;
    localparam int STG_MUL3 = 57;
    localparam int STG_MUL4 = 58;
    localparam int STG_OUT = 59;

    localparam logic [1:0] REG_STRETCH = 2'd0;
    localparam logic [1:0] REG_COMPRESS = 2'd1;
    localparam logic [1:0] REG_DAMPING = 2'd2;
    localparam logic [1:0] REG_REST = 2'd3;

    localparam logic [31:0] STIFF_RESET = 32'd6553600;
    localparam logic [46:0] MAG_CAP = {47{1'b1}};

    typedef struct packed {
        logic              zero;
        logic              stretched;
        logic              wneg;
        logic [2:0]        dneg;
        logic [2:0]        vneg;
        logic [2:0][32:0]  dmag;
        logic [2:0][32:0]  vmag;
        logic [2:0][65:0]  sq;
        logic [66:0]       rem;
        logic [33:0]       len;
        logic [2:0][50:0]  drem;
        logic [2:0][16:0]  quo;
        logic [31:0]       k;
        logic [34:0]       emag;
        logic [52:0]       s;
        logic [2:0][32:0]  pm;
        logic [2:0]        pneg;
        logic [35:0]       w;
        logic [57:0]       pklo;
        logic [58:0]       pkhi;
        logic [46:0]       m;
        logic [67:0]       hraw;
        logic [2:0][47:0]  am;
        logic [2:0][47:0]  bm;
        logic [2:0][31:0]  fout;
    } pipe_t;

endpackage

// ===== design/spring_damper_force.sv =====
// An accepted input word flows through the square, sum, root, select, divide, multiply and output stages.
// Throughput: one word per cycle; the whole pipeline advances together and
// halts only while a finished result waits on m_tready.
// The square root takes one bit per stage over 34 stages, and the three
// direction divisions take one quotient bit per stage over 17 stages.
// Reset clears all valid bits and loads the register reset values.
module spring_damper_force (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z,
    // first_vel_x, first_vel_y, first_vel_z, second_vel_x, second_vel_y, second_vel_z
    input  logic [383:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // force_x, force_y, force_z
    output logic [95:0]  m_tdata,
    // applied
    output logic         m_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    sdf_pkg::pipe_t p_reg [sdf_pkg::NUM_STAGES];
    sdf_pkg::pipe_t p_next [sdf_pkg::NUM_STAGES];
    logic [sdf_pkg::NUM_STAGES-1:0] v_reg;
    logic en;

    logic [31:0] stretch_reg, compress_reg, damping_reg, rest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stretch_reg <= sdf_pkg::STIFF_RESET;
            compress_reg <= sdf_pkg::STIFF_RESET;
            damping_reg <= '0;
            rest_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sdf_pkg::REG_STRETCH: stretch_reg <= cfg_data;
                sdf_pkg::REG_COMPRESS: compress_reg <= cfg_data;
                sdf_pkg::REG_DAMPING: damping_reg <= cfg_data;
                sdf_pkg::REG_REST: rest_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en = !v_reg[sdf_pkg::NUM_STAGES-1] || m_tready;
    assign s_tready = en;

    always_comb
    begin
        logic signed [32:0] a, b, d;
        p_next[0] = '0;
        for (int i = 0; i < 3; i++)
        begin
            a = 33'(signed'(s_tdata[32*i +: 32]));
            b = 33'(signed'(s_tdata[96 + 32*i +: 32]));
            d = b - a;
            p_next[0].dneg[i] = d[32];
            p_next[0].dmag[i] = d[32] ? 33'(-d) : 33'(d);
            a = 33'(signed'(s_tdata[192 + 32*i +: 32]));
            b = 33'(signed'(s_tdata[288 + 32*i +: 32]));
            d = b - a;
            p_next[0].vneg[i] = d[32];
            p_next[0].vmag[i] = d[32] ? 33'(-d) : 33'(d);
        end
    end

    for (genvar g = 1; g < sdf_pkg::NUM_STAGES; g++)
    begin : g_stage
        always_comb
        begin
            sdf_pkg::pipe_t c;
            logic [69:0] t;
            logic [66:0] qsum;
            logic signed [34:0] e;
            logic [50:0] dt;
            logic [49:0] pp;
            logic signed [35:0] acc;
            logic [84:0] full;
            logic [35:0] wmag;
            logic [51:0] hs;
            logic [46:0] hm;
            logic [63:0] prod;
            logic signed [49:0] gdiff, f;
            c = p_reg[g-1];
            t = '0; qsum = '0; e = '0; dt = '0; pp = '0; acc = '0; full = '0;
            wmag = '0; hs = '0; hm = '0; prod = '0; gdiff = '0; f = '0;
            if (g == sdf_pkg::STG_SQUARE)
            begin
                for (int i = 0; i < 3; i++)
                    c.sq[i] = 66'(c.dmag[i]) * 66'(c.dmag[i]);
            end
            else if (g == sdf_pkg::STG_SUM)
            begin
                qsum = 67'(c.sq[0]) + 67'(c.sq[1]) + 67'(c.sq[2]);
                c.rem = qsum;
                c.len = '0;
                c.zero = (qsum == '0);
            end
            else if (g >= sdf_pkg::STG_ROOT_FIRST && g <= sdf_pkg::STG_ROOT_LAST)
            begin
                t = (70'(c.len) << (sdf_pkg::STG_ROOT_LAST - g + 1))
                    + (70'(1) << (2 * (sdf_pkg::STG_ROOT_LAST - g)));
                if (t <= 70'(c.rem))
                begin
                    c.rem = c.rem - t[66:0];
                    c.len = c.len | (34'(1) << (sdf_pkg::STG_ROOT_LAST - g));
                end
            end
            else if (g == sdf_pkg::STG_SELECT)
            begin
                c.stretched = c.len > 34'(rest_reg);
                c.k = c.stretched ? stretch_reg : compress_reg;
                c.zero = c.zero || (c.k == '0);
                e = signed'({1'b0, c.len}) - signed'({3'b000, rest_reg});
                c.emag = e[34] ? 35'(-e) : 35'(e);
                for (int i = 0; i < 3; i++)
                begin
                    c.drem[i] = {2'b00, c.dmag[i], 16'h0000};
                    c.quo[i] = '0;
                end
            end
            else if (g >= sdf_pkg::STG_DIV_FIRST && g <= sdf_pkg::STG_DIV_LAST)
            begin
                dt = 51'(c.len) << (sdf_pkg::STG_DIV_LAST - g);
                for (int i = 0; i < 3; i++)
                begin
                    if (!c.zero && dt <= c.drem[i])
                    begin
                        c.drem[i] = c.drem[i] - dt;
                        c.quo[i] = c.quo[i] | (17'(1) << (sdf_pkg::STG_DIV_LAST - g));
                    end
                end
            end
            else if (g == sdf_pkg::STG_MUL1)
            begin
                c.s = 53'((70'(c.emag) * 70'(c.emag)) >> 16);
                for (int i = 0; i < 3; i++)
                begin
                    pp = 50'(c.vmag[i]) * 50'(c.quo[i]);
                    c.pm[i] = pp[48:16];
                    c.pneg[i] = c.vneg[i] ^ c.dneg[i];
                end
            end
            else if (g == sdf_pkg::STG_MUL2)
            begin
                for (int i = 0; i < 3; i++)
                    acc = c.pneg[i] ? acc - signed'(36'(c.pm[i]))
                                    : acc + signed'(36'(c.pm[i]));
                c.w = acc;
                c.wneg = acc[35];
                c.pklo = 58'(c.s[25:0]) * 58'(c.k);
                c.pkhi = 59'(c.s[52:26]) * 59'(c.k);
            end
            else if (g == sdf_pkg::STG_MUL3)
            begin
                full = 85'(c.pklo) + (85'(c.pkhi) << 26);
                c.m = (full[84:16] > 69'(sdf_pkg::MAG_CAP)) ? sdf_pkg::MAG_CAP : full[62:16];
                wmag = c.wneg ? 36'(-signed'(c.w)) : c.w;
                c.hraw = 68'(wmag) * 68'(damping_reg);
            end
            else if (g == sdf_pkg::STG_MUL4)
            begin
                hs = c.hraw[67:16];
                hm = (hs > 52'(sdf_pkg::MAG_CAP)) ? sdf_pkg::MAG_CAP : hs[46:0];
                for (int i = 0; i < 3; i++)
                begin
                    prod = 64'(c.m) * 64'(c.quo[i]);
                    c.am[i] = prod[63:16];
                    prod = 64'(hm) * 64'(c.quo[i]);
                    c.bm[i] = prod[63:16];
                end
            end
            else if (g == sdf_pkg::STG_OUT)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    gdiff = c.wneg ? signed'(50'(c.am[i])) + signed'(50'(c.bm[i]))
                                   : signed'(50'(c.am[i])) - signed'(50'(c.bm[i]));
                    f = (c.dneg[i] ^ !c.stretched) ? -gdiff : gdiff;
                    if (c.zero)
                        c.fout[i] = '0;
                    else if (f > 50'sh7FFFFFFF)
                        c.fout[i] = 32'h7FFFFFFF;
                    else if (f < -50'sh80000000)
                        c.fout[i] = 32'h80000000;
                    else
                        c.fout[i] = f[31:0];
                end
            end
            p_next[g] = c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[sdf_pkg::NUM_STAGES-2:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < sdf_pkg::NUM_STAGES; i++)
                p_reg[i] <= p_next[i];
        end
    end

    assign m_tvalid = v_reg[sdf_pkg::NUM_STAGES-1];
    assign m_tdata = {p_reg[sdf_pkg::STG_OUT].fout[2], p_reg[sdf_pkg::STG_OUT].fout[1],
                      p_reg[sdf_pkg::STG_OUT].fout[0]};
    assign m_tuser = !p_reg[sdf_pkg::STG_OUT].zero;

    a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("force not zero on an unapplied result");

    a_sum_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[sdf_pkg::STG_SUM] && !p_reg[sdf_pkg::STG_SUM].zero
        |-> p_reg[sdf_pkg::STG_SUM].rem != '0)
        else $error("nonzero flag with empty squared length");

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[sdf_pkg::STG_ROOT_LAST] |-> p_reg[sdf_pkg::STG_ROOT_LAST].rem
            <= 67'({p_reg[sdf_pkg::STG_ROOT_LAST].len, 1'b0}))
        else $error("square root remainder out of range");

    a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[sdf_pkg::STG_DIV_LAST] && !p_reg[sdf_pkg::STG_DIV_LAST].zero
        |-> p_reg[sdf_pkg::STG_DIV_LAST].drem[0] < 51'(p_reg[sdf_pkg::STG_DIV_LAST].len))
        else $error("division remainder not below divisor");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted word lost at pipeline entry");

endmodule
